FILE: hw/rtl/it3ch_pkg.sv
// Shared types for the three-channel interval timer.
// Item codes, per-channel command and response structs, the down-count helper.
// No dependencies.
`timescale 1ns / 1ps

package it3ch_pkg;

	localparam int MAX_CHANNELS = 3;

	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_CTRL  = 3'd2,
		OP_GATE  = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_LOW   = 2'd1,
		PH_HIGH  = 2'd2
	} phase_t;

	localparam logic [1:0] ACC_LATCH = 2'd0;
	localparam logic [1:0] ACC_LOW   = 2'd1;
	localparam logic [1:0] ACC_HIGH  = 2'd2;
	localparam logic [1:0] ACC_BOTH  = 2'd3;

	typedef struct packed {
		logic       fire;
		op_t        op;
		logic [1:0] chan;
		logic [7:0] data;
		logic       gate;
	} cmd_t;

	typedef struct packed {
		logic       rv;
		logic [7:0] rd;
		logic       pulse;
	} rsp_t;

	// decrement, with per-digit wrap to 9 in BCD
	function automatic logic [15:0] count_dec(input logic [15:0] cur, input logic bcd);
		logic [15:0] v;
		v = cur - 16'd1;
		if (bcd) begin
			for (int n = 0; n < 4; n++) begin
				if (v[4*n +: 4] == 4'hf)
					v[4*n +: 4] = 4'h9;
			end
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/it3ch_channel.sv
// One timer channel: control word, counts, latch and byte-phase state.
// Applies one command per fire and returns its read byte and out strobe.
// Depends on it3ch_pkg.
`timescale 1ns / 1ps

module it3ch_channel import it3ch_pkg::*; #(
	parameter int CH_INDEX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output rsp_t rsp
);

	logic [7:0]  cw_q;
	logic [15:0] cur_q;
	logic [15:0] init_q;
	logic [15:0] latch_q;
	logic        armed_q;
	logic        lpend_q;
	phase_t      rph_q;
	phase_t      wph_q;
	logic        gate_q;

	logic [7:0]  cw_d;
	logic [15:0] cur_d;
	logic [15:0] init_d;
	logic [15:0] latch_d;
	logic        armed_d;
	logic        lpend_d;
	phase_t      rph_d;
	phase_t      wph_d;
	logic        gate_d;

	logic [1:0]  acc;
	logic [2:0]  cmode;
	logic        hit;
	logic        hit_ctrl;
	logic        gated;
	logic [15:0] dec;
	logic [1:0]  new_acc;
	phase_t      new_ph;

	assign acc      = cw_q[5:4];
	assign cmode    = cw_q[3:1];
	assign hit      = cmd.chan == 2'(CH_INDEX);
	assign hit_ctrl = cmd.data[7:6] == 2'(CH_INDEX);
	assign gated    = (cmode != 3'd1) && (cmode != 3'd5);
	assign dec      = count_dec(cur_q, cw_q[0]);
	assign new_acc  = cmd.data[5:4];
	assign new_ph   = (new_acc == ACC_HIGH) ? PH_HIGH : PH_LOW;

	always_comb begin
		cw_d    = cw_q;
		cur_d   = cur_q;
		init_d  = init_q;
		latch_d = latch_q;
		armed_d = armed_q;
		lpend_d = lpend_q;
		rph_d   = rph_q;
		wph_d   = wph_q;
		gate_d  = gate_q;
		rsp     = '0;
		if (cmd.fire) begin
			unique case (cmd.op)
				OP_READ: begin
					if (hit) begin
						if (lpend_q) begin
							rsp.rv = 1'b1;
							if (rph_q == PH_HIGH) begin
								rsp.rd  = latch_q[15:8];
								rph_d   = PH_READY;
								lpend_d = 1'b0;
							end else begin
								rsp.rd = latch_q[7:0];
								rph_d  = PH_HIGH;
							end
						end else begin
							unique case (acc)
								ACC_LOW: begin
									rsp.rv = 1'b1;
									rsp.rd = cur_q[7:0];
									rph_d  = PH_READY;
								end
								ACC_HIGH: begin
									rsp.rv = 1'b1;
									rsp.rd = cur_q[15:8];
									rph_d  = PH_READY;
								end
								ACC_BOTH: begin
									rsp.rv = 1'b1;
									if (rph_q == PH_HIGH) begin
										rsp.rd = cur_q[15:8];
										rph_d  = PH_READY;
									end else begin
										rsp.rd = cur_q[7:0];
										rph_d  = PH_HIGH;
									end
								end
								default: ;
							endcase
						end
					end
				end
				OP_WRITE: begin
					if (hit && acc != ACC_LATCH) begin
						unique case (acc)
							ACC_LOW: begin
								init_d = {8'h00, cmd.data};
								wph_d  = PH_READY;
							end
							ACC_HIGH: begin
								init_d = {cmd.data, 8'h00};
								wph_d  = PH_READY;
							end
							default: begin
								if (wph_q == PH_HIGH) begin
									init_d = {cmd.data, init_q[7:0]};
									wph_d  = PH_READY;
								end else begin
									init_d = {8'h00, cmd.data};
									wph_d  = PH_HIGH;
								end
							end
						endcase
						if ((cmode == 3'd0 || (gated && !armed_q)) && wph_d == PH_READY) begin
							cur_d   = init_d;
							armed_d = 1'b1;
						end
					end
				end
				OP_CTRL: begin
					if (hit_ctrl) begin
						if (new_acc == ACC_LATCH) begin
							lpend_d   = 1'b1;
							latch_d   = cur_q;
							rph_d     = PH_LOW;
							rsp.pulse = cmode != 3'd0;
						end else begin
							lpend_d   = 1'b0;
							cw_d      = cmd.data;
							armed_d   = 1'b0;
							rph_d     = new_ph;
							wph_d     = new_ph;
							rsp.pulse = cmd.data[3:1] != 3'd0;
						end
					end
				end
				OP_GATE: begin
					if (hit) begin
						if (cmode != 3'd0 && !gate_q && cmd.gate && wph_q == PH_READY) begin
							cur_d   = init_q;
							armed_d = 1'b1;
						end
						gate_d = cmd.gate;
					end
				end
				OP_TICK: begin
					if (armed_q && !(gated && !gate_q)) begin
						cur_d = dec;
						if (cmode[1:0] == 2'd2) begin
							// rate generator: reload on reaching one
							if (dec == 16'h0001) begin
								rsp.pulse = 1'b1;
								if (wph_q == PH_READY) begin
									cur_d   = init_q;
									armed_d = 1'b1;
								end
							end
						end else if (dec == 16'h0000) begin
							rsp.pulse = 1'b1;
							if (cmode[1:0] == 2'd3) begin
								if (wph_q == PH_READY) begin
									cur_d   = init_q;
									armed_d = 1'b1;
								end
							end else begin
								armed_d = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q    <= '0;
			cur_q   <= '0;
			init_q  <= '0;
			latch_q <= '0;
			armed_q <= 1'b1;
			lpend_q <= 1'b1;
			rph_q   <= PH_READY;
			wph_q   <= PH_READY;
			gate_q  <= 1'b1;
		end else begin
			cw_q    <= cw_d;
			cur_q   <= cur_d;
			init_q  <= init_d;
			latch_q <= latch_d;
			armed_q <= armed_d;
			lpend_q <= lpend_d;
			rph_q   <= rph_d;
			wph_q   <= wph_d;
			gate_q  <= gate_d;
		end
	end

endmodule

FILE: hw/rtl/interval_timer_three_channel.sv
// Top level of the three-channel interval timer: input stage, channels, output stage.
// Depends on it3ch_pkg and it3ch_channel.
//
//  channel  | dir | tdata                          | tuser
//  s_axis   | in  | data[7:0], gate[8], zero pad   | mode[2:0], channel[4:3]
//  m_axis   | out | read_data[7:0], out_pulse[10:8]| read_valid[0]
//
// One transfer in gives exactly one transfer out, through the input stage and then the output register.
// Sustained rate is one item per cycle while the output is not stalled; all channels update in the same cycle.
// A stalled output register holds its result; the input stage then fills and
// s_axis_tready drops until the result is taken.
// Reset is asynchronous and puts every channel in its power-up state at once.
`timescale 1ns / 1ps

module interval_timer_three_channel import it3ch_pkg::*; #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // data[7:0], gate[8], zero[15:9]
	input  logic [4:0]  s_axis_tuser,   // mode[2:0], channel[4:3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // read_data[7:0], out_pulse[10:8], zero[15:11]
	output logic [0:0]  m_axis_tuser    // read_valid[0]
);

	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [1:0]  chan_s1;
	logic [7:0]  data_s1;
	logic        gate_s1;

	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic        rv_q;
	logic [2:0]  pulse_q;

	logic        advance;
	logic        accept;
	cmd_t        cmd;
	rsp_t        rsp [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pulse_vec;
	logic [NUM_CHANNELS-1:0] rv_vec;
	logic [7:0]  rd_any;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= s_axis_tuser[2:0];
			chan_s1 <= s_axis_tuser[4:3];
			data_s1 <= s_axis_tdata[7:0];
			gate_s1 <= s_axis_tdata[8];
		end
	end

	assign cmd.fire = advance;
	assign cmd.op   = op_t'(mode_s1);
	assign cmd.chan = chan_s1;
	assign cmd.data = data_s1;
	assign cmd.gate = gate_s1;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
		it3ch_channel #(
			.CH_INDEX(i)
		) u_ch (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.rsp   (rsp[i])
		);
		assign pulse_vec[i] = rsp[i].pulse;
		assign rv_vec[i]    = rsp[i].rv;
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < NUM_CHANNELS; i++)
			rd_any = rd_any | rsp[i].rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q    <= rd_any;
			rv_q    <= |rv_vec;
			pulse_q <= 3'(pulse_vec);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, pulse_q, rd_q};
	assign m_axis_tuser  = rv_q;

	a_one_reader: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(rv_vec))
		else $error("more than one channel answered a read");

	a_read_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[10:8] == 3'd0)
		else $error("read result carries an out strobe");

	a_no_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("read byte set without read_valid");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a full pipe");

	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 != OP_READ && mode_s1 != OP_WRITE && mode_s1 != OP_CTRL
		&& mode_s1 != OP_GATE && mode_s1 != OP_TICK
		|=> m_axis_tdata == 16'd0 && m_axis_tuser == 1'b0)
		else $error("unused item code gave a nonzero result");

endmodule

FILE: sim/interval_timer_three_channel_checker.sv
// Checker for the three-channel interval timer: watches both stream channels,
// predicts each response from the accepted items and compares it field by field.
// Depends on it3ch_pkg.
`timescale 1ns / 1ps

module interval_timer_three_channel_checker import it3ch_pkg::*; #(
	parameter int NUM_CH = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // data[7:0], gate[8], zero[15:9]
	input  logic [4:0]  s_axis_tuser,   // mode[2:0], channel[4:3]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // read_data[7:0], out_pulse[10:8], zero[15:11]
	input  logic [0:0]  m_axis_tuser,   // read_valid[0]
	output int          mismatch_count,
	output int          pending_results
);

	localparam logic [2:0] CM_TERMINAL   = 3'd0;
	localparam logic [2:0] CM_ONESHOT    = 3'd1;
	localparam logic [2:0] CM_RATE       = 3'd2;
	localparam logic [2:0] CM_SQUARE     = 3'd3;
	localparam logic [2:0] CM_HW_STROBE  = 3'd5;
	localparam logic [2:0] CM_RATE_ALT   = 3'd6;
	localparam logic [2:0] CM_SQUARE_ALT = 3'd7;

	typedef struct packed {
		logic [7:0] rd;
		logic       rv;
		logic [2:0] pulse;
	} timer_response_t;

	logic [7:0]  ctl_word   [MAX_CHANNELS];
	logic [15:0] count_now  [MAX_CHANNELS];
	logic [15:0] count_init [MAX_CHANNELS];
	logic [15:0] count_latch[MAX_CHANNELS];
	logic        armed      [MAX_CHANNELS];
	logic        latch_held [MAX_CHANNELS];
	phase_t      rd_phase   [MAX_CHANNELS];
	phase_t      wr_phase   [MAX_CHANNELS];
	logic        gate_now   [MAX_CHANNELS];

	timer_response_t expected_responses[$];
	int responses_seen;

	initial mismatch_count = 0;

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t ns: response %0d, %s mismatch: got 0x%0h, want 0x%0h",
			$time, responses_seen, field, got, want);
		mismatch_count++;
	endtask

	function automatic logic [15:0] count_down_value(logic [15:0] cur, logic bcd);
		logic [15:0] v;
		v = cur - 16'd1;
		if (bcd) begin
			if (v[3:0] == 4'hf) v[3:0] = 4'h9;
			if (v[7:4] == 4'hf) v[7:4] = 4'h9;
			if (v[11:8] == 4'hf) v[11:8] = 4'h9;
			if (v[15:12] == 4'hf) v[15:12] = 4'h9;
		end
		return v;
	endfunction

	function automatic void reload_count(int c);
		if (wr_phase[c] == PH_READY) begin
			count_now[c] = count_init[c];
			armed[c] = 1'b1;
		end
	endfunction

	function automatic logic tick_counter(int c);
		logic [2:0] m;
		logic gated;
		m = ctl_word[c][3:1];
		gated = (m != CM_ONESHOT) && (m != CM_HW_STROBE);
		if (!armed[c]) return 1'b0;
		if (gated && !gate_now[c]) return 1'b0;
		count_now[c] = count_down_value(count_now[c], ctl_word[c][0]);
		if (m == CM_RATE || m == CM_RATE_ALT) begin
			if (count_now[c] == 16'h0001) begin
				reload_count(c);
				return 1'b1;
			end
			return 1'b0;
		end
		if (count_now[c] != 16'h0000) return 1'b0;
		if (m == CM_SQUARE || m == CM_SQUARE_ALT)
			reload_count(c);
		else
			armed[c] = 1'b0;
		return 1'b1;
	endfunction

	function automatic timer_response_t predict_timer_response(logic [2:0] op, logic [1:0] ch,
			logic [7:0] d, logic g);
		timer_response_t r;
		logic [1:0] acc;
		logic [1:0] sel;
		logic [2:0] m;
		logic ok;
		r = '0;
		ok = (ch < NUM_CH);
		case (op)
			OP_READ: if (ok) begin
				if (latch_held[ch]) begin
					r.rv = 1'b1;
					if (rd_phase[ch] == PH_HIGH) begin
						r.rd = count_latch[ch][15:8];
						rd_phase[ch] = PH_READY;
						latch_held[ch] = 1'b0;
					end else begin
						r.rd = count_latch[ch][7:0];
						rd_phase[ch] = PH_HIGH;
					end
				end else begin
					case (ctl_word[ch][5:4])
						ACC_LOW: begin
							r.rv = 1'b1;
							r.rd = count_now[ch][7:0];
							rd_phase[ch] = PH_READY;
						end
						ACC_HIGH: begin
							r.rv = 1'b1;
							r.rd = count_now[ch][15:8];
							rd_phase[ch] = PH_READY;
						end
						ACC_BOTH: begin
							r.rv = 1'b1;
							if (rd_phase[ch] == PH_HIGH) begin
								r.rd = count_now[ch][15:8];
								rd_phase[ch] = PH_READY;
							end else begin
								r.rd = count_now[ch][7:0];
								rd_phase[ch] = PH_HIGH;
							end
						end
						default: ;
					endcase
				end
			end
			OP_WRITE: if (ok) begin
				acc = ctl_word[ch][5:4];
				if (acc != ACC_LATCH) begin
					case (acc)
						ACC_LOW: begin
							count_init[ch] = {8'h00, d};
							wr_phase[ch] = PH_READY;
						end
						ACC_HIGH: begin
							count_init[ch] = {d, 8'h00};
							wr_phase[ch] = PH_READY;
						end
						default: if (wr_phase[ch] == PH_HIGH) begin
							count_init[ch] = {d, count_init[ch][7:0]};
							wr_phase[ch] = PH_READY;
						end else begin
							count_init[ch] = {8'h00, d};
							wr_phase[ch] = PH_HIGH;
						end
					endcase
					m = ctl_word[ch][3:1];
					if (m == CM_TERMINAL)
						reload_count(ch);
					else if (m != CM_ONESHOT && m != CM_HW_STROBE && !armed[ch])
						reload_count(ch);
				end
			end
			OP_CTRL: begin
				sel = d[7:6];
				if (sel < NUM_CH) begin
					latch_held[sel] = 1'b0;
					if (d[5:4] == ACC_LATCH) begin
						latch_held[sel] = 1'b1;
						count_latch[sel] = count_now[sel];
						rd_phase[sel] = PH_LOW;
					end else begin
						ctl_word[sel] = d;
						armed[sel] = 1'b0;
						rd_phase[sel] = (d[5:4] == ACC_HIGH) ? PH_HIGH : PH_LOW;
						wr_phase[sel] = (d[5:4] == ACC_HIGH) ? PH_HIGH : PH_LOW;
					end
					if (ctl_word[sel][3:1] != CM_TERMINAL) r.pulse[sel] = 1'b1;
				end
			end
			OP_GATE: if (ok) begin
				if (ctl_word[ch][3:1] != CM_TERMINAL && !gate_now[ch] && g) reload_count(ch);
				gate_now[ch] = g;
			end
			OP_TICK: begin
				for (int k = 0; k < NUM_CH; k++)
					if (tick_counter(k)) r.pulse[k] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_response_t want;
		if (!arst_n) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				ctl_word[c] = '0;
				count_now[c] = '0;
				count_init[c] = '0;
				count_latch[c] = '0;
				armed[c] = 1'b1;
				latch_held[c] = 1'b1;
				rd_phase[c] = PH_READY;
				wr_phase[c] = PH_READY;
				gate_now[c] = 1'b1;
			end
			expected_responses.delete();
			responses_seen = 0;
			pending_results = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("unexpected transfer", m_axis_tdata, 0);
				end else begin
					want = expected_responses.pop_front();
					if (m_axis_tdata[7:0] != want.rd)
						report_mismatch("read_data", m_axis_tdata[7:0], want.rd);
					if (m_axis_tuser[0] != want.rv)
						report_mismatch("read_valid", m_axis_tuser[0], want.rv);
					if (m_axis_tdata[10:8] != want.pulse)
						report_mismatch("out_pulse", m_axis_tdata[10:8], want.pulse);
				end
				responses_seen++;
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_responses.push_back(predict_timer_response(s_axis_tuser[2:0],
					s_axis_tuser[4:3], s_axis_tdata[7:0], s_axis_tdata[8]));
			pending_results = expected_responses.size();
		end
	end

endmodule

FILE: sim/interval_timer_three_channel_tb.sv
// Top of the interval timer testbench: clock, reset, stimulus and verdict.
// Directed bus and tick items first, then programmed-channel runs mixed with noise.
// Depends on it3ch_pkg, interval_timer_three_channel and its checker.
`timescale 1ns / 1ps

module interval_timer_three_channel_tb;
	import it3ch_pkg::*;

	localparam int         N_CH           = 3;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] SEL_READBACK   = 2'd3;
	localparam logic [1:0] CH_ABSENT      = 2'd3;
	localparam logic [2:0] OP_UNUSED      = 3'd6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [4:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	int mismatch_count;
	int pending_results;
	int src_idle_pct = 14;
	int sink_stall_pct = 65;
	int items_sent = 0;
	int quiet_cycles = 0;

	interval_timer_three_channel #(.NUM_CHANNELS(N_CH)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	interval_timer_three_channel_checker #(.NUM_CH(N_CH)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] acc,
			logic [2:0] cnt_mode, logic bcd);
		return {sel, acc, cnt_mode, bcd};
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic [2:0] op, logic [1:0] ch, logic [7:0] d, logic g);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, g, d};
		s_axis_tuser <= {ch, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0) @(negedge clk);
	endtask

	// programmed-channel runs: control word, count bytes, then ticks mixed with bus traffic
	task automatic run_phase(int src_pct, int sink_pct, int stop_at);
		logic [1:0] ch;
		logic [1:0] acc;
		logic [2:0] cm;
		logic bcd;
		logic [15:0] count;
		int pick;
		int n_steps;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				send_item(3'($urandom_range(0, 7)), 2'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				ch = 2'($urandom_range(0, N_CH - 1));
				pick = $urandom_range(99);
				acc = (pick < 60) ? ACC_BOTH : (pick < 90) ? ACC_LOW : ACC_HIGH;
				cm = 3'($urandom_range(0, 7));
				bcd = ($urandom_range(99) < 30);
				pick = $urandom_range(99);
				count = (pick < 80) ? 16'($urandom_range(1, 12)) :
					(pick < 90) ? 16'h0000 : 16'($urandom);
				send_item(OP_CTRL, 2'($urandom), ctrl_word(ch, acc, cm, bcd), 1'($urandom));
				if (acc != ACC_HIGH) send_item(OP_WRITE, ch, count[7:0], 1'($urandom));
				if (acc != ACC_LOW) send_item(OP_WRITE, ch, count[15:8], 1'($urandom));
				if ($urandom_range(99) < 60) begin
					send_item(OP_GATE, ch, 8'($urandom), 1'b0);
					send_item(OP_GATE, ch, 8'($urandom), 1'b1);
				end
				n_steps = (count <= 16'd12) ? $urandom_range(2, 2 * count + 6) :
					$urandom_range(2, 12);
				for (int i = 0; i < n_steps; i++) begin
					pick = $urandom_range(99);
					if (pick < 70) begin
						send_item(OP_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
					end else if (pick < 82) begin
						send_item(OP_READ, 2'($urandom_range(0, N_CH - 1)), 8'($urandom),
							1'($urandom));
					end else if (pick < 88) begin
						send_item(OP_CTRL, 2'($urandom),
							ctrl_word(ch, ACC_LATCH, 3'($urandom), 1'($urandom)), 1'($urandom));
						send_item(OP_READ, ch, 8'($urandom), 1'($urandom));
						send_item(OP_READ, ch, 8'($urandom), 1'($urandom));
					end else if (pick < 94) begin
						send_item(OP_GATE, ch, 8'($urandom), 1'($urandom));
					end else begin
						send_item(OP_WRITE, ch, 8'($urandom_range(0, 15)), 1'($urandom));
					end
				end
			end
			if ($urandom_range(99) < 3) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// latch held from reset: low byte, high byte, then nothing in access mode zero
		send_item(OP_READ, 2'd0, 8'h00, 1'b0);
		send_item(OP_READ, 2'd0, 8'h00, 1'b0);
		send_item(OP_READ, 2'd0, 8'hff, 1'b1);
		send_item(OP_WRITE, 2'd0, 8'hff, 1'b1);
		send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
		send_item(OP_READ, CH_ABSENT, 8'hff, 1'b1);
		send_item(OP_CTRL, 2'd0, ctrl_word(SEL_READBACK, ACC_BOTH, 3'($urandom), 1'b1), 1'b0);
		send_item(OP_UNUSED, CH_ABSENT, 8'hff, 1'b1);
		for (int m = 0; m < 8; m++)
			send_item(OP_CTRL, 2'd0, ctrl_word(2'(m % N_CH), ACC_BOTH, 3'(m), m[0]), 1'b0);
		// channel 0 now rate generator, channel 2 hardware-triggered strobe
		send_item(OP_WRITE, 2'd0, 8'h02, 1'b0);
		send_item(OP_WRITE, 2'd0, 8'h00, 1'b0);
		send_item(OP_WRITE, 2'd2, 8'h01, 1'b0);
		send_item(OP_WRITE, 2'd2, 8'h00, 1'b0);
		send_item(OP_GATE, 2'd2, 8'h00, 1'b0);
		send_item(OP_GATE, 2'd2, 8'h00, 1'b1);
		send_item(OP_CTRL, 2'd0, ctrl_word(2'd1, ACC_LATCH, 3'($urandom), 1'($urandom)), 1'b0);
		send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
		send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
		send_item(OP_READ, 2'd1, 8'h00, 1'b0);
		wait_drained();

		run_phase(14, 65, 600);
		run_phase(65, 14, 1200);
		run_phase(0, 0, 1750);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
